[hdl/csls_pkg.sv]
// Shared types and constants for the charger status LED sequencer.
`timescale 1ns / 1ps

package csls_pkg;

	localparam int ElapsedW = 8;
	localparam int CodeW    = 8;
	localparam int CntW     = 16;
	localparam int NumBlink = 4;
	localparam int BlinkIdxW = $clog2(NumBlink);
	localparam int CfgIdxW  = 1;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_FAST_BLINK = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_SLOW_BLINK = 1'd1;

	localparam logic [CntW-1:0] FAST_BLINK_RST = 16'd200;
	localparam logic [CntW-1:0] SLOW_BLINK_RST = 16'd1000;

	// Charger state codes
	localparam logic [CodeW-1:0] ST_IDLE      = 8'd0;
	localparam logic [CodeW-1:0] ST_CONNECTED = 8'd1;
	localparam logic [CodeW-1:0] ST_STARTING  = 8'd2;
	localparam logic [CodeW-1:0] ST_CHARGING  = 8'd3;
	localparam logic [CodeW-1:0] ST_CAR_PEND  = 8'd4;
	localparam logic [CodeW-1:0] ST_STOPPED   = 8'd5;
	localparam logic [CodeW-1:0] ST_FAULT     = 8'd6;
	localparam logic [CodeW-1:0] ST_FINISHED  = 8'd7;
	localparam logic [CodeW-1:0] ST_RESERVED  = 8'd8;
	localparam logic [CodeW-1:0] ST_LAST_RST  = 8'hFF;

	localparam logic [CodeW-1:0] MODE_YELLOW  = 8'd2;
	localparam logic [CodeW-1:0] MODE_RST     = 8'd0;

	// Blinker slots
	localparam logic [BlinkIdxW-1:0] BL_CONNECTED = 2'd0;
	localparam logic [BlinkIdxW-1:0] BL_STARTING  = 2'd1;
	localparam logic [BlinkIdxW-1:0] BL_CAR_PEND  = 2'd2;
	localparam logic [BlinkIdxW-1:0] BL_STOPPED   = 2'd3;

	typedef enum logic [1:0] {
		FX_STEADY = 2'd0,
		FX_BREATH = 2'd1,
		FX_SHIFT  = 2'd2
	} fx_kind_t;

	typedef enum logic [1:0] {
		COL_GREEN  = 2'd0,
		COL_BLUE   = 2'd1,
		COL_RED    = 2'd2,
		COL_YELLOW = 2'd3
	} fx_color_t;

	typedef struct packed {
		logic      valid;
		fx_kind_t  kind;
		fx_color_t color;
	} fx_cmd_t;

	typedef struct packed {
		logic blue;
		logic green;
		logic red;
	} lines_t;

endpackage

[hdl/csls_effect.sv]
// Effect LED command selection and last state/mode tracking.
`timescale 1ns / 1ps

module csls_effect (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [csls_pkg::CodeW-1:0] charge_state,
	input  logic [csls_pkg::CodeW-1:0] run_mode,
	output csls_pkg::fx_cmd_t        cmd
);
	import csls_pkg::*;

	logic [CodeW-1:0] last_state_q;
	logic [CodeW-1:0] last_mode_q;
	logic             changed;

	assign changed = (charge_state != last_state_q) || (run_mode != last_mode_q);

	// Pick the command for a changed state or mode
	always_comb begin
		cmd = '{valid: 1'b0, kind: FX_STEADY, color: COL_GREEN};
		if (changed) begin
			cmd.valid = 1'b1;
			if (run_mode == MODE_YELLOW && charge_state != ST_FAULT) begin
				cmd.color = COL_YELLOW;
			end else begin
				case (charge_state)
					ST_IDLE:      begin cmd.kind = FX_BREATH; cmd.color = COL_GREEN;  end
					ST_CONNECTED: begin cmd.kind = FX_STEADY; cmd.color = COL_BLUE;   end
					ST_STARTING:  begin cmd.kind = FX_BREATH; cmd.color = COL_BLUE;   end
					ST_CHARGING:  begin cmd.kind = FX_SHIFT;  cmd.color = COL_BLUE;   end
					ST_CAR_PEND:  begin cmd.kind = FX_BREATH; cmd.color = COL_BLUE;   end
					ST_STOPPED:   begin cmd.kind = FX_STEADY; cmd.color = COL_GREEN;  end
					ST_FAULT:     begin cmd.kind = FX_STEADY; cmd.color = COL_RED;    end
					ST_FINISHED:  begin cmd.kind = FX_BREATH; cmd.color = COL_BLUE;   end
					ST_RESERVED:  begin cmd.kind = FX_STEADY; cmd.color = COL_YELLOW; end
					default:      cmd.valid = 1'b0;
				endcase
			end
		end
	end

	// Remember the state and mode of the latest transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= ST_LAST_RST;
			last_mode_q  <= MODE_RST;
		end else if (advance && changed) begin
			last_state_q <= charge_state;
			last_mode_q  <= run_mode;
		end
	end

endmodule

[hdl/csls_lines.sv]
// Indicator line levels with the four per-state blink counters.
`timescale 1ns / 1ps

module csls_lines (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [csls_pkg::ElapsedW-1:0] elapsed_ms,
	input  logic [csls_pkg::CodeW-1:0]    charge_state,
	input  logic [csls_pkg::CntW-1:0]     fast_blink_ms,
	input  logic [csls_pkg::CntW-1:0]     slow_blink_ms,
	output csls_pkg::lines_t            lines
);
	import csls_pkg::*;

	logic [CntW-1:0]      cnt_q [NumBlink];
	logic [NumBlink-1:0]  phase_q;
	lines_t               lines_q;

	logic                 blink_en;
	logic [BlinkIdxW-1:0] idx;
	logic [CntW-1:0]      thr;
	logic [CntW-1:0]      cnt_cur;
	logic                 flip;
	logic                 new_phase;
	logic                 lvl;
	logic [CntW-1:0]      cnt_next;

	// Map the state to its blinker slot
	always_comb begin
		blink_en = 1'b1;
		idx      = BL_CONNECTED;
		case (charge_state)
			ST_CONNECTED: idx = BL_CONNECTED;
			ST_STARTING:  idx = BL_STARTING;
			ST_CAR_PEND:  idx = BL_CAR_PEND;
			ST_STOPPED:   idx = BL_STOPPED;
			default:      blink_en = 1'b0;
		endcase
	end

	// Test the counter before adding the tick
	assign thr       = (idx == BL_STOPPED) ? slow_blink_ms : fast_blink_ms;
	assign cnt_cur   = cnt_q[idx];
	assign flip      = cnt_cur > thr;
	assign new_phase = ~phase_q[idx];
	assign cnt_next  = (flip ? '0 : cnt_cur) + CntW'(elapsed_ms);
	assign lvl       = flip ? new_phase
	                        : ((idx == BL_CONNECTED) ? lines_q.green : lines_q.blue);

	// Next line levels
	always_comb begin
		lines = lines_q;
		case (charge_state)
			ST_IDLE:      lines = '{blue: 1'b0, green: 1'b1, red: 1'b0};
			ST_CONNECTED: lines = '{blue: 1'b0, green: lvl,  red: 1'b0};
			ST_STARTING,
			ST_CAR_PEND,
			ST_STOPPED:   lines = '{blue: lvl,  green: 1'b0, red: 1'b0};
			ST_CHARGING:  lines = '{blue: 1'b1, green: 1'b0, red: 1'b0};
			ST_FAULT:     lines = '{blue: 1'b0, green: 1'b0, red: 1'b1};
			default:      lines = lines_q;
		endcase
	end

	// Advance the active blinker and hold the others
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumBlink; i++) begin
				cnt_q[i] <= '0;
			end
			phase_q <= '0;
			lines_q <= '0;
		end else if (advance) begin
			lines_q <= lines;
			for (int i = 0; i < NumBlink; i++) begin
				if (blink_en && idx == BlinkIdxW'(i)) begin
					cnt_q[i] <= cnt_next;
					if (flip) begin
						phase_q[i] <= new_phase;
					end
				end
			end
		end
	end

endmodule

[hdl/charger_status_led_sequencer_top.sv]
// Top level: input register, status logic and output register of the LED sequencer.
// Path: a tick is held in the input register, then in the output register, which presents it on the master side.
// Throughput: one tick per cycle while m_tready is high; input register and output register each hold one
// tick, with the single status logic pass between them.
// Reset: arst_n clears valid flags, blink counters, phases and line levels, loads
// the blink thresholds with 200 and 1000, and sets the last state to 255, mode 0.
`timescale 1ns / 1ps

module charger_status_led_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes
	input  logic                         cfg_we,
	input  logic [csls_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0]                  cfg_data,
	// Tick stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // elapsed_ms[7:0], charge_state[15:8], run_mode[23:16]
	// Status stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // red_on[0], green_on[1], blue_on[2], anim_tick_ms[10:3],
	                              // effect_cmd_valid[11], effect_kind[13:12], effect_color[15:14]
);
	import csls_pkg::*;

	logic [CntW-1:0]     fast_blink_q;
	logic [CntW-1:0]     slow_blink_q;

	logic                valid_s1;
	logic [ElapsedW-1:0] elapsed_s1;
	logic [CodeW-1:0]    state_s1;
	logic [CodeW-1:0]    mode_s1;

	logic                valid_s2;
	lines_t              lines_s2;
	logic [ElapsedW-1:0] anim_s2;
	fx_cmd_t             cmd_s2;

	logic                advance;
	fx_cmd_t             cmd;
	lines_t              lines;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_blink_q <= FAST_BLINK_RST;
			slow_blink_q <= SLOW_BLINK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAST_BLINK: fast_blink_q <= cfg_data;
				REG_SLOW_BLINK: slow_blink_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			elapsed_s1 <= s_tdata[7:0];
			state_s1   <= s_tdata[15:8];
			mode_s1    <= s_tdata[23:16];
		end
	end

	csls_effect u_effect (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.charge_state (state_s1),
		.run_mode     (mode_s1),
		.cmd          (cmd)
	);

	csls_lines u_lines (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.elapsed_ms    (elapsed_s1),
		.charge_state  (state_s1),
		.fast_blink_ms (fast_blink_q),
		.slow_blink_ms (slow_blink_q),
		.lines         (lines)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lines_s2 <= lines;
			anim_s2  <= elapsed_s1;
			cmd_s2   <= cmd;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {cmd_s2.color, cmd_s2.kind, cmd_s2.valid, anim_s2,
	                   lines_s2.blue, lines_s2.green, lines_s2.red};

`ifndef SYNTHESIS
	a_ready_low_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input side stalled without a full pipeline");

	a_one_line_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones({lines_s2.red, lines_s2.green, lines_s2.blue}) <= 1)
		else $error("more than one indicator line on");

	a_idle_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !cmd_s2.valid) |-> (cmd_s2.kind == FX_STEADY && cmd_s2.color == COL_GREEN))
		else $error("effect fields not cleared without a command");

	a_shift_is_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cmd_s2.valid && cmd_s2.kind == FX_SHIFT) |-> cmd_s2.color == COL_BLUE)
		else $error("shifting effect with a color other than blue");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> (valid_s2 && $stable(m_tdata)))
		else $error("output transfer dropped or changed while stalled");
`endif

endmodule
